// ===== sv/tabulated_spectrum_sampler_core_defines.svh =====
// Assertion macros shared by the spectrum sampler RTL.
`ifndef TABULATED_SPECTRUM_SAMPLER_CORE_DEFINES_SVH
`define TABULATED_SPECTRUM_SAMPLER_CORE_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define TSS_ASSERT_NOW(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define TSS_ASSERT_NEXT(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

// ===== sv/tss_pkg.sv =====
// Shared constants and codes for the spectrum sampler.
package tss_pkg;

  localparam int DEF_TABLE_DEPTH = 1024;
  localparam int DEF_ENERGY_BITS = 24;
  localparam int DEF_PROB_BITS   = 32;

  localparam int AREA_BITS  = 56;
  localparam int INT_BITS   = 16;
  localparam int OUT_E_BITS = 24;

  localparam logic [1:0] REQ_CLEAR    = 2'd0;
  localparam logic [1:0] REQ_APPEND   = 2'd1;
  localparam logic [1:0] REQ_SAMPLE   = 2'd2;
  localparam logic [1:0] REQ_RESERVED = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

endpackage

// ===== sv/tss_divider.sv =====
// Bit-serial scaled fraction unit: floor(mult * num / den) with num <= den.
module tss_divider import tss_pkg::*; #(
  parameter int MULT_BITS = DEF_ENERGY_BITS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [MULT_BITS-1:0] mult,
  input  logic [AREA_BITS-1:0] num,
  input  logic [AREA_BITS-1:0] den,
  output logic                 done,
  output logic [MULT_BITS-1:0] quot
);

  localparam int CNT_W = $clog2(MULT_BITS + 1);
  localparam int TW    = AREA_BITS + 2;

  logic [MULT_BITS-1:0] mult_q;
  logic [AREA_BITS-1:0] num_q;
  logic [AREA_BITS-1:0] den_q;
  logic [AREA_BITS-1:0] rem;
  logic [CNT_W-1:0]     steps;
  logic                 busy;

  logic [TW-1:0] t;
  logic [TW-1:0] den1;
  logic [TW-1:0] den2;
  logic [TW-1:0] t_next;
  logic [1:0]    qinc;

  // The partial remainder stays below den, so at most two subtractions fit.
  always_comb begin
    den1 = TW'(den_q);
    den2 = TW'(den_q) << 1;
    t    = (TW'(rem) << 1) + (mult_q[MULT_BITS-1] ? TW'(num_q) : '0);
    if (t >= den2) begin
      t_next = t - den2;
      qinc   = 2'd2;
    end else if (t >= den1) begin
      t_next = t - den1;
      qinc   = 2'd1;
    end else begin
      t_next = t;
      qinc   = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= !start && busy && (steps == CNT_W'(1));
      if (start) begin
        busy   <= 1'b1;
        steps  <= CNT_W'(MULT_BITS);
        mult_q <= mult;
        num_q  <= num;
        den_q  <= den;
        rem    <= '0;
        quot   <= '0;
      end else if (busy) begin
        mult_q <= mult_q << 1;
        rem    <= t_next[AREA_BITS-1:0];
        quot   <= (quot << 1) + MULT_BITS'(qinc);
        steps  <= steps - 1'b1;
        if (steps == CNT_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

endmodule

// ===== sv/tabulated_spectrum_sampler_core.sv =====
// Spectrum sampler top level: point table memory, binary search and interpolation.
// Clear goes straight to the output state; append computes in S_APP and writes in S_APPW.
// A sample's duration is set by one table read per search step and the one-bit-per-cycle
// interpolation divider. One item is in work at a time.
// A finished result waits in the output register while the next item is taken.
// Reset empties the table at once; memory contents are not cleared.
`include "tabulated_spectrum_sampler_core_defines.svh"
module tabulated_spectrum_sampler_core import tss_pkg::*; #(
  parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
  parameter int ENERGY_BITS = DEF_ENERGY_BITS,
  parameter int PROB_BITS   = DEF_PROB_BITS
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  // point_energy, point_intensity, probability, zero fill
  input  logic [((ENERGY_BITS+INT_BITS+PROB_BITS+7)/8)*8-1:0] s_tdata,
  // req_type
  input  logic [1:0] s_tuser,
  output logic m_tvalid,
  input  logic m_tready,
  // sampled_energy
  output logic [OUT_E_BITS-1:0] m_tdata,
  // status
  output logic [1:0] m_tuser
);

  localparam int IW  = $clog2(TABLE_DEPTH);
  localparam int CW  = $clog2(TABLE_DEPTH + 1);
  localparam int MW  = ENERGY_BITS + AREA_BITS;
  localparam int SW  = INT_BITS + 1 + ENERGY_BITS;
  localparam int XW  = ENERGY_BITS + OUT_E_BITS;
  localparam int AREA_LO = 32;

  typedef enum logic [3:0] {
    S_IDLE, S_APP, S_APPW, S_MUL1, S_MUL2, S_TGT, S_SRCH, S_CMP,
    S_RDJ, S_GETJ, S_GETP, S_CHK, S_DIV, S_OUT
  } state_t;

  state_t state;

  logic [MW-1:0] mem [TABLE_DEPTH];
  logic [MW-1:0] rd_data;
  logic [IW-1:0] rd_addr;
  logic          mem_we;
  logic [MW-1:0] wr_data;

  logic [CW-1:0]          count;
  logic [INT_BITS-1:0]    last_int;
  logic [ENERGY_BITS-1:0] last_e;
  logic [AREA_BITS-1:0]   last_a;

  logic [ENERGY_BITS-1:0] app_e;
  logic [INT_BITS-1:0]    app_int;
  logic [SW-1:0]          seg;
  logic [PROB_BITS-1:0]   prob_q;
  logic [PROB_BITS+AREA_LO-1:0]             prod_lo;
  logic [PROB_BITS+AREA_BITS-AREA_LO-1:0]   prod_hi;
  logic [AREA_BITS-1:0]   target;
  logic [IW-1:0]          lo;
  logic [IW-1:0]          hi;
  logic [IW-1:0]          mid;
  logic [IW-1:0]          mid_q;
  logic [ENERGY_BITS-1:0] ej;
  logic [AREA_BITS-1:0]   aj;
  logic [ENERGY_BITS-1:0] pe;
  logic [AREA_BITS-1:0]   pa;
  logic [ENERGY_BITS-1:0] res_e;
  logic [1:0]             res_st;

  logic [ENERGY_BITS-1:0] prev_e;
  logic [AREA_BITS-1:0]   prev_a;
  logic [AREA_BITS:0]     sum;
  logic [AREA_BITS-1:0]   sum_sat;
  logic [XW-1:0]          res_ext;

  logic                   div_start;
  logic                   div_done;
  logic [ENERGY_BITS-1:0] div_q;

  logic [ENERGY_BITS-1:0] in_e;
  logic [INT_BITS-1:0]    in_int;
  logic [PROB_BITS-1:0]   in_prob;

  assign in_e    = s_tdata[ENERGY_BITS-1:0];
  assign in_int  = s_tdata[ENERGY_BITS+INT_BITS-1:ENERGY_BITS];
  assign in_prob = s_tdata[ENERGY_BITS+INT_BITS+PROB_BITS-1:ENERGY_BITS+INT_BITS];

  assign s_tready = (state == S_IDLE);

  assign prev_e  = (count == '0) ? '0 : last_e;
  assign prev_a  = (count == '0) ? '0 : last_a;
  assign sum     = (AREA_BITS+1)'(prev_a) + (AREA_BITS+1)'(seg);
  assign sum_sat = sum[AREA_BITS] ? '1 : sum[AREA_BITS-1:0];
  assign mid     = lo + ((hi - lo) >> 1);
  assign mem_we  = (state == S_APPW);
  assign wr_data = {sum_sat, app_e};
  assign res_ext = XW'(res_e);

  always_comb begin
    unique case (state)
      S_SRCH:  rd_addr = mid;
      S_RDJ:   rd_addr = lo;
      default: rd_addr = lo - 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[count[IW-1:0]] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  tss_divider #(
    .MULT_BITS(ENERGY_BITS)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .mult  (ej - pe),
    .num   (target - pa),
    .den   (aj - pa),
    .done  (div_done),
    .quot  (div_q)
  );

  assign div_start = (state == S_CHK) && !((target <= pa) || (ej <= pe));

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      last_int <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && state != S_OUT) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            res_e   <= '0;
            app_e   <= in_e;
            app_int <= in_int;
            prob_q  <= in_prob;
            unique case (s_tuser)
              REQ_CLEAR: begin
                count    <= '0;
                last_int <= '0;
                res_st   <= ST_OK;
                state    <= S_OUT;
              end
              REQ_APPEND: begin
                if (count == CW'(TABLE_DEPTH)) begin
                  res_st <= ST_FULL;
                  state  <= S_OUT;
                end else begin
                  res_st <= ST_OK;
                  state  <= S_APP;
                end
              end
              REQ_SAMPLE: begin
                if (count == '0 || last_a == '0) begin
                  res_st <= ST_EMPTY;
                  state  <= S_OUT;
                end else begin
                  res_st <= ST_OK;
                  state  <= S_MUL1;
                end
              end
              default: begin
                res_st <= ST_OK;
                state  <= S_OUT;
              end
            endcase
          end
        end
        S_APP: begin
          seg <= SW'((INT_BITS+1)'(last_int) + (INT_BITS+1)'(app_int))
               * SW'((app_e > prev_e) ? app_e - prev_e : '0);
          state <= S_APPW;
        end
        S_APPW: begin
          last_e   <= app_e;
          last_a   <= sum_sat;
          last_int <= app_int;
          count    <= count + 1'b1;
          state    <= S_OUT;
        end
        S_MUL1: begin
          prod_lo <= (PROB_BITS+AREA_LO)'(prob_q) * (PROB_BITS+AREA_LO)'(last_a[AREA_LO-1:0]);
          state   <= S_MUL2;
        end
        S_MUL2: begin
          prod_hi <= (PROB_BITS+AREA_BITS-AREA_LO)'(prob_q)
                   * (PROB_BITS+AREA_BITS-AREA_LO)'(last_a[AREA_BITS-1:AREA_LO]);
          state   <= S_TGT;
        end
        S_TGT: begin
          target <= (AREA_BITS'(prod_hi) << (AREA_LO - PROB_BITS))
                  + AREA_BITS'(prod_lo >> PROB_BITS);
          lo     <= '0;
          hi     <= IW'(count - 1'b1);
          state  <= S_SRCH;
        end
        S_SRCH: begin
          mid_q <= mid;
          state <= (lo < hi) ? S_CMP : S_RDJ;
        end
        S_CMP: begin
          if (rd_data[MW-1:ENERGY_BITS] >= target) begin
            hi <= mid_q;
          end else begin
            lo <= mid_q + 1'b1;
          end
          state <= S_SRCH;
        end
        S_RDJ: begin
          state <= S_GETJ;
        end
        S_GETJ: begin
          ej <= rd_data[ENERGY_BITS-1:0];
          aj <= rd_data[MW-1:ENERGY_BITS];
          if (lo == '0) begin
            // The first segment starts at the origin.
            pe    <= '0;
            pa    <= '0;
            state <= S_CHK;
          end else begin
            state <= S_GETP;
          end
        end
        S_GETP: begin
          pe    <= rd_data[ENERGY_BITS-1:0];
          pa    <= rd_data[MW-1:ENERGY_BITS];
          state <= S_CHK;
        end
        S_CHK: begin
          res_e <= pe;
          state <= div_start ? S_DIV : S_OUT;
        end
        S_DIV: begin
          if (div_done) begin
            res_e <= pe + div_q;
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= res_ext[OUT_E_BITS-1:0];
            m_tuser  <= res_st;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `TSS_ASSERT_NOW(a_count_bound, 1'b1, count <= CW'(TABLE_DEPTH), "point count beyond table depth")
  `TSS_ASSERT_NOW(a_search_order, state == S_SRCH || state == S_CMP, lo <= hi, "search bounds crossed")
  `TSS_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "accepted while busy")
  `TSS_ASSERT_NOW(a_div_done_state, div_done, state == S_DIV, "divider finished outside its wait")

endmodule

// ===== verif/tabulated_spectrum_sampler_core_checker.sv =====
// Checker for the spectrum sampler: watches both channels, predicts results and compares them.
`timescale 1ns / 100ps
module tabulated_spectrum_sampler_core_checker import tss_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [71:0] s_tdata,
  input  logic [1:0]  s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [23:0] m_tdata,
  input  logic [1:0]  m_tuser,
  output int          fail_count,
  output int          pending_count
);

  localparam int DEPTH = DEF_TABLE_DEPTH;
  localparam logic [AREA_BITS-1:0] AREA_SAT = {AREA_BITS{1'b1}};

  typedef struct packed {
    logic [23:0] energy;
    logic [1:0]  status;
  } sample_result_t;

  logic [23:0]          energies [DEPTH];
  logic [AREA_BITS-1:0] areas [DEPTH];
  int                   n_points;
  logic [15:0]          prev_intensity;
  sample_result_t       expected_results [$];

  // Bit-serial floor(mult * num / den), with num <= den.
  function automatic logic [23:0] interp_offset(logic [23:0] mult, logic [AREA_BITS-1:0] num,
                                                logic [AREA_BITS-1:0] den);
    logic [63:0] rem;
    logic [63:0] t;
    logic [23:0] q;
    rem = 0;
    q = 0;
    for (int b = 23; b >= 0; b--) begin
      t = rem << 1;
      q = q << 1;
      if (mult[b]) t = t + num;
      while (t >= den) begin
        t = t - den;
        q = q + 1;
      end
      rem = t;
    end
    return q;
  endfunction

  function automatic sample_result_t predict_request(logic [1:0] req, logic [23:0] e,
                                                     logic [15:0] inten, logic [31:0] prob);
    sample_result_t r;
    logic [23:0] pe;
    logic [AREA_BITS-1:0] pa, total, target;
    logic [63:0] seg;
    logic [AREA_BITS:0] sum;
    logic [88:0] prod;
    int lo, hi, mid;
    r = '{energy: '0, status: ST_OK};
    pe = 0;
    pa = 0;
    case (req)
      REQ_CLEAR: begin
        n_points = 0;
        prev_intensity = 0;
      end
      REQ_APPEND: begin
        if (n_points >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          if (n_points > 0) begin
            pe = energies[n_points-1];
            pa = areas[n_points-1];
          end
          seg = 0;
          if (e > pe) seg = (64'(prev_intensity) + 64'(inten)) * 64'(e - pe);
          sum = {1'b0, pa} + (AREA_BITS+1)'(seg);
          if (sum > {1'b0, AREA_SAT}) sum = {1'b0, AREA_SAT};
          energies[n_points] = e;
          areas[n_points] = sum[AREA_BITS-1:0];
          n_points++;
          prev_intensity = inten;
        end
      end
      REQ_SAMPLE: begin
        total = (n_points > 0) ? areas[n_points-1] : '0;
        if (n_points == 0 || total == 0) begin
          r.status = ST_EMPTY;
        end else begin
          prod = 89'(prob) * 89'(total);
          target = prod[87:32];
          lo = 0;
          hi = n_points - 1;
          while (lo < hi) begin
            mid = lo + (hi - lo) / 2;
            if (areas[mid] >= target) hi = mid;
            else lo = mid + 1;
          end
          if (lo > 0) begin
            pe = energies[lo-1];
            pa = areas[lo-1];
          end
          if (target <= pa || energies[lo] <= pe) r.energy = pe;
          else r.energy = pe + interp_offset(energies[lo] - pe, target - pa, areas[lo] - pa);
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    sample_result_t got, want;
    int errs;
    errs = 0;
    if (rst) begin
      n_points = 0;
      prev_intensity = 0;
      expected_results.delete();
    end else begin
      if (s_tvalid && s_tready)
        expected_results = {expected_results,
                            predict_request(s_tuser, s_tdata[23:0], s_tdata[39:24],
                                            s_tdata[71:40])};
      if (m_tvalid && m_tready) begin
        got = '{energy: m_tdata, status: m_tuser};
        if (expected_results.size() == 0) begin
          $error("unexpected result transaction: energy %0d status %0d", got.energy, got.status);
          errs++;
        end else begin
          want = expected_results.pop_front();
          if (got.energy !== want.energy) begin
            $error("sampled_energy: expected %0d, actual %0d", want.energy, got.energy);
            errs++;
          end
          if (got.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, got.status);
            errs++;
          end
        end
      end
    end
    fail_count <= rst ? 0 : fail_count + errs;
    pending_count <= expected_results.size();
  end

endmodule

// ===== verif/tabulated_spectrum_sampler_core_tb.sv =====
// Testbench top for the spectrum sampler: drives requests, stalls the output and gives the verdict.
`timescale 1ns / 100ps
module tabulated_spectrum_sampler_core_tb;
  import tss_pkg::*;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [71:0] s_tdata;
  logic [1:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [23:0] m_tdata;
  logic [1:0]  m_tuser;
  int          fail_count;
  int          pending_count;
  logic        send_done;

  tabulated_spectrum_sampler_core DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  tabulated_spectrum_sampler_core_checker checker_i (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .fail_count(fail_count), .pending_count(pending_count)
  );

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  function automatic int gap_length();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(1, 4);
    return $urandom_range(10, 70);
  endfunction

  // Holds one request until the block takes it, then, when gaps are allowed, may idle for a random gap.
  task automatic send_request(logic [1:0] req, logic [23:0] e, logic [15:0] inten,
                              logic [31:0] prob, bit allow_gap);
    int gap;
    s_tvalid <= 1'b1;
    s_tuser  <= req;
    s_tdata  <= {prob, inten, e};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    gap = allow_gap ? gap_length() : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_spectrum(int points, bit rising);
    logic [23:0] e;
    e = 24'($urandom_range(0, 4000));
    for (int k = 0; k < points; k++) begin
      if (rising || $urandom_range(0, 5) != 0) e = e + 24'($urandom_range(0, 60000));
      else e = 24'($urandom_range(0, 24'hFFFFFF));
      send_request(REQ_APPEND, e, 16'($urandom_range(0, 16'hFFFF)), $urandom, 1);
    end
  endtask

  task automatic send_samples(int count);
    for (int k = 0; k < count; k++)
      send_request(REQ_SAMPLE, 24'($urandom), 16'($urandom), $urandom, 1);
  endtask

  // Output stalls: random backpressure, with ready drawn independently at each clock edge and mostly high.
  always @(posedge clk) begin
    if (rst) m_tready <= 1'b0;
    else if (($urandom_range(0, 999)) < 5) m_tready <= 1'b1;
    else m_tready <= ($urandom_range(0, 3) != 0) || ($urandom_range(0, 200) == 0);
  end

  initial begin
    s_tvalid = 0;
    s_tdata = '0;
    s_tuser = REQ_CLEAR;
    rst = 1;
    send_done = 0;
    repeat (11) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: empty table, unused code, first segment, zero area, flat and falling parts.
    send_request(REQ_SAMPLE, 0, 0, 32'hFFFF_FFFF, 0);
    send_request(REQ_RESERVED, 24'hFFFFFF, 16'hFFFF, 32'hFFFF_FFFF, 0);
    send_request(REQ_APPEND, 24'd1000, 16'd0, 0, 0);
    send_request(REQ_SAMPLE, 0, 0, 32'h8000_0000, 0);
    send_request(REQ_APPEND, 24'd5000, 16'hFFFF, 0, 0);
    send_request(REQ_APPEND, 24'd3000, 16'd100, 0, 0);
    send_request(REQ_APPEND, 24'hFFFFFF, 16'hFFFF, 0, 0);
    send_request(REQ_SAMPLE, 0, 0, 32'd0, 0);
    send_request(REQ_SAMPLE, 0, 0, 32'hFFFF_FFFF, 0);
    send_request(REQ_SAMPLE, 0, 0, 32'h0000_0001, 0);
    send_request(REQ_SAMPLE, 0, 0, 32'h5555_5555, 0);
    send_request(REQ_SAMPLE, 0, 0, 32'hAAAA_AAAA, 0);
    send_request(REQ_CLEAR, 24'hFFFFFF, 16'hFFFF, 32'hFFFF_FFFF, 0);
    send_request(REQ_SAMPLE, 0, 0, 32'h1234_5678, 0);
    send_request(REQ_APPEND, 24'd0, 16'hFFFF, 0, 0);
    send_request(REQ_APPEND, 24'd0, 16'hFFFF, 0, 0);
    send_request(REQ_SAMPLE, 0, 0, 32'h8000_0000, 0);
    send_request(REQ_APPEND, 24'hFFFFFF, 16'hFFFF, 0, 0);
    send_request(REQ_SAMPLE, 0, 0, 32'hFFFF_FFFF, 0);
    send_request(REQ_SAMPLE, 0, 0, 32'h0000_0000, 0);

    // Drain everything once before the random part.
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);

    // Build a long spectrum and sample it.
    send_request(REQ_CLEAR, 0, 0, 0, 0);
    send_spectrum(400, 0);
    for (int k = 0; k < 3; k++)
      send_request(REQ_APPEND, 24'($urandom), 16'($urandom), 0, 1);
    send_samples(20);

    // Random sessions: mostly short spectra followed by samples, with some noise.
    for (int s = 0; s < 12; s++) begin
      if ($urandom_range(0, 4) != 0)
        send_request(REQ_CLEAR, 24'($urandom), 16'($urandom), $urandom, 1);
      send_spectrum($urandom_range(1, 12), $urandom_range(0, 2) != 0);
      send_samples($urandom_range(3, 14));
      if ($urandom_range(0, 5) == 0)
        send_request(($urandom_range(0, 1) == 0) ? REQ_RESERVED : REQ_SAMPLE,
                     24'($urandom), 16'($urandom), $urandom, 1);
    end

    s_tvalid <= 1'b0;
    send_done = 1;
  end

  initial begin
    @(negedge rst);
    wait (send_done);
    repeat (2) @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fail_count == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

  initial begin
    #20ms;
    $display("status: fail");
    $finish;
  end

endmodule
